[hw/rtl/hpcs_pkg.sv]
// Shared types and constants for the precharge and contactor sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hpcs_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_FRACTION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VALID_TIME_MS      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_READS     = 2'd2;

    localparam logic [15:0] THRESHOLD_FRACTION_RESET = 16'd58982;
    localparam logic [15:0] VALID_TIME_MS_RESET      = 16'd500;
    localparam logic [3:0]  DEBOUNCE_READS_RESET     = 4'd3;

    localparam int FRAC_BITS = 16;

    localparam logic [2:0] MODE_IDLE          = 3'd0;
    localparam logic [2:0] MODE_PRECHARGE     = 3'd1;
    localparam logic [2:0] MODE_ENERGIZED     = 3'd2;
    localparam logic [2:0] MODE_CHG_PRECHARGE = 3'd3;
    localparam logic [2:0] MODE_CHARGING      = 3'd4;

    typedef struct packed {
        logic        any_fault;
        logic [31:0] tick_ms;
        logic [15:0] tractive_volts;
        logic [15:0] pack_volts;
        logic        shutdown_raw;
        logic        charger_present;
    } hpcs_in_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       contactor_closed;
        logic       shutdown_level;
    } hpcs_out_t;

    typedef struct packed {
        logic fault;
        logic closed;
        logic charger;
    } hpcs_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/hpcs_debounce.sv]
// Shutdown loop debouncer: level changes after a run of differing reads.
`timescale 1ns / 1ps
`default_nettype none

module hpcs_debounce (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic       raw,
    input  wire logic [3:0] reads,
    output logic            level
);
    import hpcs_pkg::*;

    logic       level_reg;
    logic       level_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [3:0] count_inc;

    assign count_inc = count_reg + 4'd1;

    always_comb
    begin
        level_next = level_reg;
        count_next = 4'd0;
        if (raw != level_reg)
        begin
            count_next = count_inc;
            if (count_inc >= reads)
            begin
                level_next = raw;
                count_next = 4'd0;
            end
        end
    end

    assign level = step_en ? level_next : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            count_reg <= 4'd0;
        end
        else if (step_en)
        begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hpcs_fsm.sv]
// Sequencer state machine with precharge threshold test and timer.
`timescale 1ns / 1ps
`default_nettype none

module hpcs_fsm #(
    parameter int VOLT_BITS = 16,
    parameter int TICK_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_en,
    input  wire hpcs_pkg::hpcs_ctl_t  ctl,
    input  wire logic [TICK_BITS-1:0] tick,
    input  wire logic [VOLT_BITS-1:0] trac,
    input  wire logic [VOLT_BITS-1:0] pack,
    input  wire logic [15:0]          threshold_fraction,
    input  wire logic [15:0]          valid_time_ms,
    output logic [2:0]                mode,
    output logic                      contactor
);
    import hpcs_pkg::*;

    localparam int PROD_BITS = VOLT_BITS + FRAC_BITS;

    logic [2:0]           mode_reg;
    logic [2:0]           mode_next;
    logic                 contactor_reg;
    logic                 contactor_next;
    logic [TICK_BITS-1:0] start_tick_reg;
    logic [TICK_BITS-1:0] start_tick_next;
    logic [PROD_BITS-1:0] trac_scaled;
    logic [PROD_BITS-1:0] limit;
    logic [TICK_BITS-1:0] elapsed;
    logic                 above;
    logic                 timed_out;
    logic                 done;

    assign trac_scaled = {trac, {FRAC_BITS{1'b0}}};
    assign limit       = PROD_BITS'(pack) * PROD_BITS'(threshold_fraction);
    assign above       = trac_scaled > limit;
    assign elapsed     = tick - start_tick_reg;
    assign timed_out   = elapsed >= TICK_BITS'(valid_time_ms);
    assign done        = above && timed_out;

    always_comb
    begin
        mode_next       = mode_reg;
        contactor_next  = contactor_reg;
        start_tick_next = start_tick_reg;
        if (ctl.fault)
        begin
            mode_next      = MODE_IDLE;
            contactor_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    contactor_next = 1'b0;
                    if (ctl.closed)
                    begin
                        start_tick_next = tick;
                        mode_next = ctl.charger ? MODE_CHG_PRECHARGE : MODE_PRECHARGE;
                    end
                end
                MODE_PRECHARGE:
                begin
                    if (!above)
                    begin
                        start_tick_next = tick;
                    end
                    if (done)
                    begin
                        contactor_next = 1'b1;
                        mode_next      = MODE_ENERGIZED;
                    end
                    if (!ctl.closed)
                    begin
                        contactor_next = 1'b0;
                        mode_next      = MODE_IDLE;
                    end
                end
                MODE_ENERGIZED:
                begin
                    if (!ctl.closed)
                    begin
                        contactor_next = 1'b0;
                        mode_next      = MODE_IDLE;
                    end
                end
                MODE_CHG_PRECHARGE:
                begin
                    if (!above)
                    begin
                        start_tick_next = tick;
                    end
                    if (done)
                    begin
                        contactor_next = 1'b1;
                        mode_next      = MODE_CHARGING;
                    end
                    if (!ctl.charger)
                    begin
                        contactor_next = 1'b0;
                        mode_next      = MODE_IDLE;
                    end
                end
                MODE_CHARGING:
                begin
                    if (!ctl.charger)
                    begin
                        contactor_next = 1'b0;
                        mode_next      = MODE_IDLE;
                    end
                end
                default:
                begin
                    contactor_next = 1'b0;
                    mode_next      = MODE_IDLE;
                end
            endcase
        end
    end

    assign mode      = mode_next;
    assign contactor = contactor_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            contactor_reg  <= 1'b0;
            start_tick_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            contactor_reg  <= contactor_next;
            start_tick_reg <= start_tick_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hv_precharge_contactor_sequencer_unit.sv]
// Top level of the high-voltage precharge and contactor sequencer.
// Usage:
//   in_valid/in_ready/in_data carry one update request: fault flag, ms tick,
//   tractive and pack voltages, raw shutdown loop level and charger flag.
//   out_valid/out_ready/out_data return one result per request: the mode,
//   the positive contactor command and the debounced shutdown level.
//   cfg_we/cfg_index/cfg_data write threshold_fraction (0), valid_time_ms (1)
//   and debounce_reads (2); write them only while no request is in flight.
// Timing:
//   A request is registered in the input register at acceptance and its result
//   is registered in the output register when the stage advances. One request
//   is taken every cycle while out_ready is high; the combinational state update
//   (debounce, threshold multiply and compare, mode step) bounds the rate.
// Reset:
//   rst_n clears the pipeline, selects idle with the contactor open and the
//   shutdown level open, and loads the register defaults.
// Stall:
//   When out_ready is low the result holds; one more request is taken into
//   the input register, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module hv_precharge_contactor_sequencer_unit #(
    parameter int VOLT_BITS = 16,
    parameter int TICK_BITS = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire hpcs_pkg::hpcs_in_t                      in_data,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output hpcs_pkg::hpcs_out_t                          out_data,
    input  wire logic                                    cfg_we,
    input  wire logic [hpcs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [hpcs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import hpcs_pkg::*;

    hpcs_in_t             in_reg;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    hpcs_out_t            out_reg;
    hpcs_out_t            out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 advance;
    logic                 accept;
    logic [15:0]          threshold_fraction_reg;
    logic [15:0]          valid_time_ms_reg;
    logic [3:0]           debounce_reads_reg;
    logic                 level;
    logic [2:0]           mode;
    logic                 contactor;
    hpcs_ctl_t            ctl;
    logic [TICK_BITS-1:0] tick;
    logic [VOLT_BITS-1:0] trac;
    logic [VOLT_BITS-1:0] pack;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign stage_valid_next = accept || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_fraction_reg <= THRESHOLD_FRACTION_RESET;
            valid_time_ms_reg      <= VALID_TIME_MS_RESET;
            debounce_reads_reg     <= DEBOUNCE_READS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD_FRACTION: threshold_fraction_reg <= cfg_data[15:0];
                CFG_VALID_TIME_MS:      valid_time_ms_reg      <= cfg_data[15:0];
                CFG_DEBOUNCE_READS:     debounce_reads_reg     <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign tick = TICK_BITS'(in_reg.tick_ms);
    assign trac = VOLT_BITS'(in_reg.tractive_volts);
    assign pack = VOLT_BITS'(in_reg.pack_volts);

    hpcs_debounce u_debounce (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance && !in_reg.any_fault),
        .raw     (in_reg.shutdown_raw),
        .reads   (debounce_reads_reg),
        .level   (level)
    );

    assign ctl.fault   = in_reg.any_fault;
    assign ctl.closed  = level;
    assign ctl.charger = in_reg.charger_present;

    hpcs_fsm #(
        .VOLT_BITS (VOLT_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_fsm (
        .clk                (clk),
        .rst_n              (rst_n),
        .step_en            (advance),
        .ctl                (ctl),
        .tick               (tick),
        .trac               (trac),
        .pack               (pack),
        .threshold_fraction (threshold_fraction_reg),
        .valid_time_ms      (valid_time_ms_reg),
        .mode               (mode),
        .contactor          (contactor)
    );

    assign out_next.mode             = mode;
    assign out_next.contactor_closed = contactor;
    assign out_next.shutdown_level   = level;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_closed_only_when_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.contactor_closed |->
            (out_reg.mode == MODE_ENERGIZED || out_reg.mode == MODE_CHARGING))
        else $error("contactor closed outside energized or charging");

    a_fault_opens: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.any_fault |=>
            (out_reg.mode == MODE_IDLE && !out_reg.contactor_closed))
        else $error("fault request did not return to idle");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.mode <= MODE_CHARGING)
        else $error("unused mode code on output");

    a_ready_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stage_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while pipeline has room");
`endif

endmodule

`default_nettype wire
